### rtl/v3a_pkg.sv
// Shared opcodes, status struct and saturation helper for the vector ALU.
package v3a_pkg;

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_SCALE   = 4'd2,
    FN_DOT     = 4'd3,
    FN_CROSS   = 4'd4,
    FN_MAG     = 4'd5,
    FN_NORM    = 4'd6,
    FN_REFLECT = 4'd7,
    FN_EQ      = 4'd8
  } v3a_func_e;

  localparam int unsigned TOL_BITS = 31;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd66;

  // width of the clamp helper's input and of its value field
  localparam int unsigned SAT_XW = 160;
  localparam int unsigned SAT_W  = 64;

  typedef struct packed {
    v3a_func_e func;
    logic      eq;
    logic      sat;
  } v3a_stat_t;

  // Clamp v to a signed w-bit word. Bit SAT_W is the clamp flag, the low w bits the value.
  function automatic logic [SAT_W:0] sat_word(input logic signed [SAT_XW-1:0] v,
                                              input int unsigned w);
    logic signed [SAT_XW-1:0] top;
    logic [SAT_W-1:0]         lim;
    logic [SAT_W:0]           r;
    top = v >>> (w - 1);
    lim = (SAT_W'(1) << (w - 1)) - SAT_W'(1);
    if (top == '0 || top == '1) begin
      r = {1'b0, v[SAT_W-1:0]};
    end else if (v[SAT_XW-1]) begin
      r = {1'b1, lim + SAT_W'(1)};
    end else begin
      r = {1'b1, lim};
    end
    return r;
  endfunction

endpackage

### rtl/vector3_alu_core.sv
// Top level of the three-component fixed-point vector ALU.
// Signed fixed-point vector ALU (WORD_BITS wide, FRAC_BITS fraction bits): add, sub,
// scale, dot, cross, magnitude, normalize, reflect and a tolerance compare. It takes one
// transaction per clock while in_ready_o is high and returns one result per transaction,
// in order. Every opcode passes through the same stages: five front stages for products
// and sums, WORD_BITS square-root stages (one root bit each), 2*FRAC_BITS+1 reciprocal
// divider stages (one quotient bit each) and two back stages for the normalize multiply
// and the output register. When a result waits at the output, the whole pipeline holds
// and in_ready_o drops. The tolerance register resets to 66 and should be written only
// while the pipeline is empty; its write port is always ready.
module vector3_alu_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [v3a_pkg::TOL_BITS-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [3:0]                       func_i,
  input  logic signed [WORD_BITS-1:0]      a_x_i,
  input  logic signed [WORD_BITS-1:0]      a_y_i,
  input  logic signed [WORD_BITS-1:0]      a_z_i,
  input  logic signed [WORD_BITS-1:0]      b_x_i,
  input  logic signed [WORD_BITS-1:0]      b_y_i,
  input  logic signed [WORD_BITS-1:0]      b_z_i,
  input  logic signed [WORD_BITS-1:0]      scale_factor_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [WORD_BITS-1:0]      r_x_o,
  output logic signed [WORD_BITS-1:0]      r_y_o,
  output logic signed [WORD_BITS-1:0]      r_z_o,
  output logic signed [WORD_BITS-1:0]      scalar_result_o,
  output logic                             equal_flag_o,
  output logic                             saturated_o
);
  import v3a_pkg::*;

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned MID = WORD_BITS + 2 * FRAC_BITS + 1;

  logic [TOL_BITS-1:0]  tol_q;
  logic                 adv;

  logic                 f_valid;
  v3a_stat_t            f_stat;
  logic [2:0][W-1:0]    f_r, f_a, a_vec, b_vec, o_r;
  logic [W-1:0]         f_sc, root, mag, o_sc;
  logic [2*W-1:0]       f_sumsq;
  logic [2*FRAC_BITS:0] recip;

  logic [MID-1:0]       dv_q;
  v3a_stat_t            dst_q [MID];
  logic [2:0][W-1:0]    dr_q  [MID];
  logic [W-1:0]         dsc_q [MID];
  logic [2:0][W-1:0]    da_q  [MID];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // single pipeline enable: move unless the output holds an untaken result
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign a_vec = {a_z_i, a_y_i, a_x_i};
  assign b_vec = {b_z_i, b_y_i, b_x_i};

  v3a_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .func_i  (func_i),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .s_i     (scale_factor_i),
    .tol_i   (tol_q),
    .valid_o (f_valid),
    .stat_o  (f_stat),
    .r_o     (f_r),
    .sc_o    (f_sc),
    .a_o     (f_a),
    .sumsq_o (f_sumsq)
  );

  v3a_isqrt #(.WORD_BITS(WORD_BITS)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .s_i    (f_sumsq),
    .root_o (root)
  );

  v3a_recip #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_recip (
    .clk_i (clk_i),
    .en_i  (adv),
    .m_i   (root),
    .q_o   (recip),
    .m_o   (mag)
  );

  // side data rides alongside the root and divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (adv) begin
      dv_q <= {dv_q[MID-2:0], f_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dst_q[0] <= f_stat;
      dr_q[0]  <= f_r;
      dsc_q[0] <= f_sc;
      da_q[0]  <= f_a;
      for (int k = 1; k < MID; k++) begin
        dst_q[k] <= dst_q[k-1];
        dr_q[k]  <= dr_q[k-1];
        dsc_q[k] <= dsc_q[k-1];
        da_q[k]  <= da_q[k-1];
      end
    end
  end

  v3a_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dv_q[MID-1]),
    .stat_i  (dst_q[MID-1]),
    .r_i     (dr_q[MID-1]),
    .sc_i    (dsc_q[MID-1]),
    .a_i     (da_q[MID-1]),
    .mag_i   (mag),
    .recip_i (recip),
    .valid_o (out_valid_o),
    .r_o     (o_r),
    .sc_o    (o_sc),
    .eq_o    (equal_flag_o),
    .sat_o   (saturated_o)
  );

  assign r_x_o           = o_r[0];
  assign r_y_o           = o_r[1];
  assign r_z_o           = o_r[2];
  assign scalar_result_o = o_sc;

  // a compare result carries no vector, scalar or clamp
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && equal_flag_o |->
      r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && scalar_result_o == '0 && !saturated_o)
    else $error("compare result with nonzero payload");

  a_rise_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output valid rose during a stall");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(dv_q))
    else $error("middle pipeline moved during a stall");

endmodule

### rtl/v3a_front.sv
// Front pipeline: operand select, products, sums, add/sub/scale/dot/cross/reflect, equality.
module v3a_front #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [3:0]                        func_i,
  input  logic [2:0][WORD_BITS-1:0]         a_i,
  input  logic [2:0][WORD_BITS-1:0]         b_i,
  input  logic [WORD_BITS-1:0]              s_i,
  input  logic [v3a_pkg::TOL_BITS-1:0]      tol_i,
  output logic                              valid_o,
  output v3a_pkg::v3a_stat_t                stat_o,
  output logic [2:0][WORD_BITS-1:0]         r_o,
  output logic [WORD_BITS-1:0]              sc_o,
  output logic [2:0][WORD_BITS-1:0]         a_o,
  output logic [2*WORD_BITS-1:0]            sumsq_o
);
  import v3a_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned RW = 2 * W + 2;

  logic [4:0] v_q;

  // stage 0: input register
  v3a_func_e             func0_q;
  logic [2:0][W-1:0]     a0_q, b0_q;
  logic [W-1:0]          s0_q;

  // stage 1: products
  v3a_func_e             func1_q;
  logic [2:0][W-1:0]     a1_q, b1_q, r1_q, r1_d;
  logic                  sat1_q, sat1_d, eq1_q, eq1_d;
  logic signed [PW-1:0]  m1_q [6];
  logic signed [PW-1:0]  m1_d [6];
  logic [5:0][W-1:0]     opa, opb;

  // stage 2: sums
  v3a_func_e             func2_q;
  logic [2:0][W-1:0]     a2_q, b2_q, r2_q, r2_d;
  logic [W-1:0]          sc2_q, sc2_d, d2_q, d2_d;
  logic                  sat2_q, sat2_d, eq2_q;
  logic [PW-1:0]         sumsq2_q, sumsq2_d;

  // stage 3: reflect products
  v3a_func_e             func3_q;
  logic [2:0][W-1:0]     a3_q, r3_q;
  logic [W-1:0]          sc3_q;
  logic                  sat3_q, eq3_q;
  logic [PW-1:0]         sumsq3_q;
  logic signed [PW:0]    p3_q [3];
  logic signed [PW:0]    p3_d [3];

  // stage 4: output register
  logic [2:0][W-1:0]     r4_d;
  logic                  sat4_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func0_q <= v3a_func_e'(func_i);
      a0_q    <= a_i;
      b0_q    <= b_i;
      s0_q    <= s_i;
    end
  end

  always_comb begin
    logic signed [W:0] sum_c;
    logic [W:0]        ad;
    logic [SAT_W:0]    t;
    opa    = '0;
    opb    = '0;
    r1_d   = '0;
    sat1_d = 1'b0;
    eq1_d  = 1'b0;
    sum_c  = '0;
    ad     = '0;
    t      = '0;
    case (func0_q)
      FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0_q[i];
          opb[i] = s0_q;
        end
      end
      FN_DOT, FN_REFLECT: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0_q[i];
          opb[i] = b0_q[i];
        end
      end
      FN_CROSS: begin
        opa[0] = a0_q[1]; opb[0] = b0_q[2];
        opa[1] = a0_q[2]; opb[1] = b0_q[1];
        opa[2] = a0_q[2]; opb[2] = b0_q[0];
        opa[3] = a0_q[0]; opb[3] = b0_q[2];
        opa[4] = a0_q[0]; opb[4] = b0_q[1];
        opa[5] = a0_q[1]; opb[5] = b0_q[0];
      end
      FN_MAG, FN_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0_q[i];
          opb[i] = a0_q[i];
        end
      end
      FN_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sum_c = $signed({a0_q[i][W-1], a0_q[i]}) + $signed({b0_q[i][W-1], b0_q[i]});
          t = sat_word(SAT_XW'(sum_c), W);
          r1_d[i] = t[W-1:0];
          sat1_d = sat1_d | t[SAT_W];
        end
      end
      FN_SUB: begin
        for (int i = 0; i < 3; i++) begin
          sum_c = $signed({a0_q[i][W-1], a0_q[i]}) - $signed({b0_q[i][W-1], b0_q[i]});
          t = sat_word(SAT_XW'(sum_c), W);
          r1_d[i] = t[W-1:0];
          sat1_d = sat1_d | t[SAT_W];
        end
      end
      FN_EQ: begin
        eq1_d = 1'b1;
        for (int i = 0; i < 3; i++) begin
          sum_c = $signed({a0_q[i][W-1], a0_q[i]}) - $signed({b0_q[i][W-1], b0_q[i]});
          ad = sum_c[W] ? $unsigned(-sum_c) : $unsigned(sum_c);
          if (64'(ad) >= 64'(tol_i)) begin
            eq1_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      m1_d[k] = $signed(opa[k]) * $signed(opb[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func1_q <= func0_q;
      a1_q    <= a0_q;
      b1_q    <= b0_q;
      r1_q    <= r1_d;
      sat1_q  <= sat1_d;
      eq1_q   <= eq1_d;
      for (int k = 0; k < 6; k++) begin
        m1_q[k] <= m1_d[k];
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] diff;
    logic [SAT_W:0]       t;
    sum = SW'(m1_q[0]) + SW'(m1_q[1]) + SW'(m1_q[2]);
    diff     = '0;
    t        = '0;
    r2_d     = r1_q;
    sc2_d    = '0;
    d2_d     = '0;
    sat2_d   = sat1_q;
    sumsq2_d = sum[PW-1:0];
    case (func1_q)
      FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          t = sat_word(SAT_XW'(m1_q[i] >>> F), W);
          r2_d[i] = t[W-1:0];
          sat2_d = sat2_d | t[SAT_W];
        end
      end
      FN_DOT: begin
        t = sat_word(SAT_XW'(sum >>> F), W);
        sc2_d = t[W-1:0];
        sat2_d = t[SAT_W];
      end
      FN_REFLECT: begin
        t = sat_word(SAT_XW'(sum >>> F), W);
        d2_d = t[W-1:0];
        sat2_d = t[SAT_W];
      end
      FN_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          diff = SW'(m1_q[2*i]) - SW'(m1_q[2*i+1]);
          t = sat_word(SAT_XW'(diff >>> F), W);
          r2_d[i] = t[W-1:0];
          sat2_d = sat2_d | t[SAT_W];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func2_q  <= func1_q;
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      r2_q     <= r2_d;
      sc2_q    <= sc2_d;
      d2_q     <= d2_d;
      sat2_q   <= sat2_d;
      eq2_q    <= eq1_q;
      sumsq2_q <= sumsq2_d;
    end
  end

  // b * 2d for reflect; 2d is exact in W+1 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p3_d[i] = $signed(b2_q[i]) * $signed({d2_q, 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func3_q  <= func2_q;
      a3_q     <= a2_q;
      r3_q     <= r2_q;
      sc3_q    <= sc2_q;
      sat3_q   <= sat2_q;
      eq3_q    <= eq2_q;
      sumsq3_q <= sumsq2_q;
      for (int i = 0; i < 3; i++) begin
        p3_q[i] <= p3_d[i];
      end
    end
  end

  always_comb begin
    logic signed [RW-1:0] rd;
    logic [SAT_W:0]       t;
    rd     = '0;
    t      = '0;
    r4_d   = r3_q;
    sat4_d = sat3_q;
    if (func3_q == FN_REFLECT) begin
      for (int i = 0; i < 3; i++) begin
        rd = RW'($signed(a3_q[i])) - RW'(p3_q[i] >>> F);
        t = sat_word(SAT_XW'(rd), W);
        r4_d[i] = t[W-1:0];
        sat4_d = sat4_d | t[SAT_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stat_o.func <= func3_q;
      stat_o.eq   <= eq3_q;
      stat_o.sat  <= sat4_d;
      r_o         <= r4_d;
      sc_o        <= sc3_q;
      a_o         <= a3_q;
      sumsq_o     <= sumsq3_q;
    end
  end

  assign valid_o = v_q[4];

endmodule

### rtl/v3a_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module v3a_isqrt #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [2*WORD_BITS-1:0]   s_i,
  output logic [WORD_BITS-1:0]     root_o
);
  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * W;

  logic [PW-1:0] x_q   [W-1];
  logic [PW-1:0] res_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam logic [PW-1:0] ONE = PW'(1) << (2 * (W - 1 - k));
    logic [PW-1:0] x_in, r_in, x_d, r_d, trial;

    if (k == 0) begin : g_first
      assign x_in = s_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = res_q[k-1];
    end

    always_comb begin
      trial = r_in + ONE;
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + ONE;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[k] <= r_d;
      end
    end

    // the last stage's remainder is not needed
    if (k < W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k] <= x_d;
        end
      end
    end
  end

  assign root_o = res_q[W-1][W-1:0];

endmodule

### rtl/v3a_recip.sv
// Pipelined restoring divider for 2^(2*FRAC_BITS) / m, one quotient bit per stage.
module v3a_recip #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [WORD_BITS-1:0]     m_i,
  output logic [2*FRAC_BITS:0]     q_o,
  output logic [WORD_BITS-1:0]     m_o
);
  localparam int unsigned W = WORD_BITS;
  localparam int unsigned Q = 2 * FRAC_BITS + 1;

  logic [W-1:0] rem_q [Q-1];
  logic [Q-1:0] q_q   [Q];
  logic [W-1:0] m_q   [Q];

  for (genvar j = 0; j < Q; j++) begin : g_stage
    logic [W-1:0] rem_in, m_in, rem_d;
    logic [Q-1:0] q_in;
    logic         nbit, ge;
    logic [W:0]   sh;

    // numerator has a single one in its top bit
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign m_in   = m_i;
      assign q_in   = '0;
      assign nbit   = 1'b1;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign m_in   = m_q[j-1];
      assign q_in   = q_q[j-1];
      assign nbit   = 1'b0;
    end

    always_comb begin
      sh = {rem_in, nbit};
      ge = (sh >= {1'b0, m_in});
      rem_d = ge ? W'(sh - {1'b0, m_in}) : sh[W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j] <= {q_in[Q-2:0], ge};
        m_q[j] <= m_in;
      end
    end

    if (j < Q - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= rem_d;
        end
      end
    end
  end

  assign q_o = q_q[Q-1];
  assign m_o = m_q[Q-1];

endmodule

### rtl/v3a_back.sv
// Back pipeline: normalize multiply, magnitude clamp and the output register.
module v3a_back #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  v3a_pkg::v3a_stat_t           stat_i,
  input  logic [2:0][WORD_BITS-1:0]    r_i,
  input  logic [WORD_BITS-1:0]         sc_i,
  input  logic [2:0][WORD_BITS-1:0]    a_i,
  input  logic [WORD_BITS-1:0]         mag_i,
  input  logic [2*FRAC_BITS:0]         recip_i,
  output logic                         valid_o,
  output logic [2:0][WORD_BITS-1:0]    r_o,
  output logic [WORD_BITS-1:0]         sc_o,
  output logic                         eq_o,
  output logic                         sat_o
);
  import v3a_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned Q  = 2 * F + 1;
  localparam int unsigned NW = W + Q + 1;

  logic [1:0]            v_q;
  v3a_stat_t             stat_q;
  logic [2:0][W-1:0]     r_q, r_d;
  logic [W-1:0]          sc_q, sc_d, mag_q;
  logic                  sat_d;
  logic signed [NW-1:0]  p_q [3];
  logic signed [NW-1:0]  p_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_d[i] = $signed(a_i[i]) * $signed({1'b0, recip_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stat_q <= stat_i;
      r_q    <= r_i;
      sc_q   <= sc_i;
      mag_q  <= mag_i;
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= p_d[i];
      end
    end
  end

  always_comb begin
    logic [SAT_W:0] t;
    t     = '0;
    r_d   = r_q;
    sc_d  = sc_q;
    sat_d = stat_q.sat;
    case (stat_q.func)
      FN_MAG: begin
        t = sat_word(SAT_XW'({1'b0, mag_q}), W);
        sc_d = t[W-1:0];
        sat_d = t[SAT_W];
      end
      FN_NORM: begin
        // zero magnitude leaves the zero vector from the front end
        if (mag_q != '0) begin
          for (int i = 0; i < 3; i++) begin
            t = sat_word(SAT_XW'(p_q[i] >>> F), W);
            r_d[i] = t[W-1:0];
            sat_d = sat_d | t[SAT_W];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o   <= r_d;
      sc_o  <= sc_d;
      eq_o  <= stat_q.eq;
      sat_o <= sat_d;
    end
  end

  assign valid_o = v_q[1];

endmodule
